FILE: rtl/core/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// shared types, character codes and helpers for the echo escape decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ecd_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_OCT    = 3'd4,
    MODE_STOP   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_ARG  = 2'd1,
    OP_LINE = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  pend;
    logic [1:0]  oct_cnt;
  } dec_state_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    dec_state_t      next;
  } dec_res_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ecd_decode.sv
// ----------------------------------------------------------------------------
// ecd_decode
// combinational escape decode: up to three output words and next state
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_decode import ecd_pkg::*; (
  input  var dec_state_t state_i,
  input  var logic [1:0] op_i,
  input  var logic [7:0] byte_i,
  output dec_res_t       res_o
);

  logic [4:0] hex;
  logic       is_oct;
  logic [7:0] oct_val;
  logic [1:0] oct_nxt;
  logic [7:0] end_ch;

  assign hex     = hex_digit(byte_i);
  assign is_oct  = (byte_i >= CH_ZERO) && (byte_i <= CH_SEVEN);
  assign oct_val = {state_i.pend[4:0], byte_i[2:0]};
  assign oct_nxt = state_i.oct_cnt + 2'd1;
  assign end_ch  = (op_i == OP_ARG) ? CH_SPACE : CH_NL;

  always_comb begin
    res_o       = '0;
    res_o.next  = state_i;
    if (op_i == OP_NONE || state_i.mode == MODE_STOP) begin
      res_o.count = 2'd0;
    end else if (op_i == OP_DATA) begin
      unique case (state_i.mode)
        MODE_ESC: begin
          res_o.next.mode = MODE_NORMAL;
          res_o.count     = 2'd1;
          unique case (byte_i)
            CH_A:      res_o.bytes[0] = 8'd7;
            CH_B:      res_o.bytes[0] = 8'd8;
            CH_F:      res_o.bytes[0] = 8'd12;
            CH_N:      res_o.bytes[0] = 8'd10;
            CH_R:      res_o.bytes[0] = 8'd13;
            CH_T:      res_o.bytes[0] = 8'd9;
            CH_V:      res_o.bytes[0] = 8'd11;
            CH_BSLASH,
            CH_SQUOTE,
            CH_DQUOTE: res_o.bytes[0] = byte_i;
            CH_C: begin
              res_o.next.mode = MODE_STOP;
              res_o.count     = 2'd0;
            end
            CH_X: begin
              res_o.next.mode = MODE_HEX0;
              res_o.next.pend = 8'd0;
              res_o.count     = 2'd0;
            end
            CH_ZERO: begin
              res_o.next.mode    = MODE_OCT;
              res_o.next.pend    = 8'd0;
              res_o.next.oct_cnt = 2'd0;
              res_o.count        = 2'd0;
            end
            default: begin
              res_o.bytes[0] = CH_BSLASH;
              res_o.bytes[1] = byte_i;
              res_o.count    = 2'd2;
            end
          endcase
        end
        MODE_HEX0: begin
          if (hex[4]) begin
            res_o.next.pend = {4'd0, hex[3:0]};
            res_o.next.mode = MODE_HEX1;
          end else begin
            res_o.bytes[0]  = CH_BSLASH;
            res_o.bytes[1]  = CH_X;
            res_o.bytes[2]  = byte_i;
            res_o.count     = 2'd3;
            res_o.next.mode = MODE_NORMAL;
          end
        end
        MODE_HEX1: begin
          res_o.next.mode = MODE_NORMAL;
          if (hex[4]) begin
            res_o.bytes[0] = {state_i.pend[3:0], hex[3:0]};
            res_o.count    = 2'd1;
          end else begin
            res_o.bytes[0] = state_i.pend;
            res_o.bytes[1] = byte_i;
            res_o.count    = 2'd2;
          end
        end
        MODE_OCT: begin
          if (is_oct && state_i.oct_cnt < OCT_DIGITS) begin
            res_o.next.pend    = oct_val;
            res_o.next.oct_cnt = oct_nxt;
            if (oct_nxt >= OCT_DIGITS) begin
              res_o.bytes[0]  = oct_val;
              res_o.count     = 2'd1;
              res_o.next.mode = MODE_NORMAL;
            end
          end else begin
            res_o.bytes[0] = state_i.pend;
            if (byte_i == CH_BSLASH) begin
              res_o.count     = 2'd1;
              res_o.next.mode = MODE_ESC;
            end else begin
              res_o.bytes[1]  = byte_i;
              res_o.count     = 2'd2;
              res_o.next.mode = MODE_NORMAL;
            end
          end
        end
        default: begin
          if (byte_i == CH_BSLASH) begin
            res_o.next.mode = MODE_ESC;
          end else begin
            res_o.bytes[0]  = byte_i;
            res_o.count     = 2'd1;
            res_o.next.mode = MODE_NORMAL;
          end
        end
      endcase
    end else begin
      res_o.next.mode = MODE_NORMAL;
      unique case (state_i.mode)
        MODE_ESC: begin
          res_o.bytes[0] = CH_BSLASH;
          res_o.bytes[1] = end_ch;
          res_o.count    = 2'd2;
        end
        MODE_HEX0: begin
          res_o.bytes[0] = CH_BSLASH;
          res_o.bytes[1] = CH_X;
          res_o.bytes[2] = end_ch;
          res_o.count    = 2'd3;
        end
        MODE_HEX1,
        MODE_OCT: begin
          res_o.bytes[0] = state_i.pend;
          res_o.bytes[1] = end_ch;
          res_o.count    = 2'd2;
        end
        default: begin
          res_o.bytes[0] = end_ch;
          res_o.count    = 2'd1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/echo_escape_decoder.sv
// ----------------------------------------------------------------------------
// echo_escape_decoder
// stream decoder for echo-style backslash escapes, one word in per cycle
// ----------------------------------------------------------------------------
// path: input word register, then result buffer, to the first output word
// throughput: one input word per cycle while each word yields at most one
//   output word and the output side is ready; a word yielding two or three
//   output words holds the input side while the three-entry buffer drains
// reset: asynchronous, active low; decoder returns to plain text mode
// ----------------------------------------------------------------------------
`default_nettype none

module echo_escape_decoder import ecd_pkg::*; (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       s_axis_tvalid,
  output logic           s_axis_tready,
  input  var logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  var logic [1:0] s_axis_tuser,   // [1:0] op
  output logic           m_axis_tvalid,
  input  var logic       m_axis_tready,
  output logic [7:0]     m_axis_tdata,   // [7:0] out_byte
  output logic           m_axis_tlast
);

  logic            in_vld_q;
  logic [1:0]      in_op_q;
  logic [7:0]      in_byte_q;
  dec_state_t      state_q;
  dec_res_t        dec;
  logic [2:0][7:0] buf_q;
  logic [1:0]      cnt_q;
  logic            take;
  logic            load;

  ecd_decode u_decode (
    .state_i (state_q),
    .op_i    (in_op_q),
    .byte_i  (in_byte_q),
    .res_o   (dec)
  );

  assign take          = m_axis_tvalid && m_axis_tready;
  assign load          = in_vld_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready));
  assign s_axis_tready = !in_vld_q || load;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = (cnt_q == 2'd1);

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_NORMAL;
      state_q.pend    <= 8'd0;
      state_q.oct_cnt <= 2'd0;
    end else if (load) begin
      state_q <= dec.next;
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= dec.count;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= dec.bytes;
    end else if (take) begin
      buf_q <= {8'd0, buf_q[2], buf_q[1]};
    end
  end

endmodule

`default_nettype wire
